// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define KDPC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("kdpc assertion failed");

// Same, but the property also holds during reset.
`define KDPC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("kdpc assertion failed");

`endif

// ===== sv/kdpc_pkg.sv =====
`default_nettype none

package kdpc_pkg;

  localparam int TICK_W      = 16;
  localparam int MASK_W      = 8;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  // Register indexes on the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PRESS_LEVEL    = 8'd0,
    REG_DEBOUNCE_TICKS = 8'd1,
    REG_SHORT_MAX      = 8'd2,
    REG_LONG_MIN       = 8'd3
  } reg_index_t;

  // Reset values of the registers
  localparam logic              RST_PRESS_LEVEL = 1'b0;
  localparam logic [TICK_W-1:0] RST_DEBOUNCE    = 16'd2;
  localparam logic [TICK_W-1:0] RST_SHORT_MAX   = 16'd50;
  localparam logic [TICK_W-1:0] RST_LONG_MIN    = 16'd100;

  typedef struct packed {
    logic              press_level;
    logic [TICK_W-1:0] debounce_ticks;
    logic [TICK_W-1:0] short_max_ticks;
    logic [TICK_W-1:0] long_min_ticks;
  } kdpc_cfg_t;

  // Release classification of one key on one tick
  typedef struct packed {
    logic short_hit;
    logic normal_hit;
    logic long_hit;
  } key_evt_t;

endpackage

`default_nettype wire

// ===== sv/key_debounce_press_classifier_core.sv =====
// A result is registered in the output stage, or in the skid stage while the output stalls.
// Throughput: one item per cycle while the skid stage is empty; every key lane steps in parallel on each accepted item.
// A two-entry output stage (register plus skid) lets one more item be taken while a result waits.
// Reset (synchronous, rst high): every key idle with a zero tick count,
// registers at 0 / 2 / 50 / 100, output stages empty.
`default_nettype none

module key_debounce_press_classifier_core
  import kdpc_pkg::*;
#(
  parameter int NUM_KEYS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [MASK_W-1:0]      pin_levels,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [MASK_W-1:0]           short_events,
  output logic [MASK_W-1:0]           normal_events,
  output logic [MASK_W-1:0]           long_events
);

  // Keys above the eighth see no pin and report outside the masks,
  // so only the visible ones get a lane.
  localparam int LANES = (NUM_KEYS < MASK_W) ? NUM_KEYS : MASK_W;

  kdpc_cfg_t cfg;
  key_evt_t  evts [LANES];
  logic      take;

  assign cfg_ready = 1'b1;
  assign take      = in_valid && in_ready;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_level     <= RST_PRESS_LEVEL;
      cfg.debounce_ticks  <= RST_DEBOUNCE;
      cfg.short_max_ticks <= RST_SHORT_MAX;
      cfg.long_min_ticks  <= RST_LONG_MIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PRESS_LEVEL:    cfg.press_level     <= cfg_data[0];
        REG_DEBOUNCE_TICKS: cfg.debounce_ticks  <= cfg_data[TICK_W-1:0];
        REG_SHORT_MAX:      cfg.short_max_ticks <= cfg_data[TICK_W-1:0];
        REG_LONG_MIN:       cfg.long_min_ticks  <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // One lane per visible key
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    kdpc_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .advance (take),
      .level   (pin_levels[k]),
      .cfg     (cfg),
      .evt     (evts[k])
    );
  end

  kdpc_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .evts        (evts),
    .room        (in_ready),
    .res_valid   (out_valid),
    .res_ready   (out_ready),
    .short_mask  (short_events),
    .normal_mask (normal_events),
    .long_mask   (long_events)
  );

endmodule

`default_nettype wire

// ===== sv/kdpc_lane.sv =====
`default_nettype none

module kdpc_lane
  import kdpc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      advance,
  input  wire logic      level,
  input  wire kdpc_cfg_t cfg,
  output key_evt_t       evt
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_FIRST   = 2'd1,
    PH_FILTER  = 2'd2,
    PH_PRESSED = 2'd3
  } phase_t;

  phase_t            phase;
  logic [TICK_W-1:0] ticks;
  logic              pressed;

  assign pressed = (level == cfg.press_level);

  // Classify on release from the pressed phase; short test first
  always_comb begin
    evt = '0;
    if (phase == PH_PRESSED && !pressed) begin
      if (ticks < cfg.short_max_ticks) begin
        evt.short_hit = 1'b1;
      end else if (ticks > cfg.long_min_ticks) begin
        evt.long_hit = 1'b1;
      end else begin
        evt.normal_hit = 1'b1;
      end
    end
  end

  // Per-key phase machine and tick counter, stepped once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      ticks <= '0;
    end else if (advance) begin
      unique case (phase)
        PH_IDLE: begin
          if (pressed) begin
            phase <= PH_FIRST;
            ticks <= '0;
          end
        end
        PH_FIRST: begin
          phase <= pressed ? PH_FILTER : PH_IDLE;
        end
        PH_FILTER: begin
          // pin is not looked at while filtering
          if (ticks < cfg.debounce_ticks) begin
            ticks <= ticks + 1'b1;
          end else begin
            phase <= PH_PRESSED;
            ticks <= '0;
          end
        end
        PH_PRESSED: begin
          if (pressed) begin
            if (ticks != '1) ticks <= ticks + 1'b1;
          end else begin
            phase <= PH_IDLE;
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/kdpc_merge.sv =====
`default_nettype none

module kdpc_merge
  import kdpc_pkg::*;
#(
  parameter int LANES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire key_evt_t    evts [LANES],
  output logic             room,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [MASK_W-1:0] short_mask,
  output logic [MASK_W-1:0] normal_mask,
  output logic [MASK_W-1:0] long_mask
);

  logic [MASK_W-1:0] s_next, n_next, l_next;
  logic [MASK_W-1:0] skid_s, skid_n, skid_l;
  logic              skid_valid;

  // Gather lane findings into the three masks
  always_comb begin
    s_next = '0;
    n_next = '0;
    l_next = '0;
    for (int k = 0; k < LANES; k++) begin
      s_next[k] = evts[k].short_hit;
      n_next[k] = evts[k].normal_hit;
      l_next[k] = evts[k].long_hit;
    end
  end

  assign room = !skid_valid;

  // Output register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res_valid && !res_ready) begin
      if (take) begin
        skid_valid <= 1'b1;
        skid_s     <= s_next;
        skid_n     <= n_next;
        skid_l     <= l_next;
      end
    end else if (skid_valid) begin
      res_valid   <= 1'b1;
      skid_valid  <= 1'b0;
      short_mask  <= skid_s;
      normal_mask <= skid_n;
      long_mask   <= skid_l;
    end else begin
      res_valid <= take;
      if (take) begin
        short_mask  <= s_next;
        normal_mask <= n_next;
        long_mask   <= l_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/kdpc_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module kdpc_checker
  import kdpc_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [MASK_W-1:0] short_events,
  input wire logic [MASK_W-1:0] normal_events,
  input wire logic [MASK_W-1:0] long_events
);

  // a release is classified into at most one mask
  `KDPC_ASSERT(a_one_class, clk, rst, out_valid |-> (((short_events & normal_events) == '0) && ((short_events & long_events) == '0) && ((normal_events & long_events) == '0)))

  // input never blocked while the output stage is empty
  `KDPC_ASSERT(a_no_block, clk, rst, !out_valid |-> in_ready)

  // input only closes after a stalled result
  `KDPC_ASSERT(a_close_on_stall, clk, rst, $fell(in_ready) |-> $past(out_valid && !out_ready))

  // a stalled item holds its payload
  `KDPC_ASSERT(a_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(short_events) && $stable(normal_events) && $stable(long_events)))

endmodule

bind key_debounce_press_classifier_core kdpc_checker u_kdpc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .short_events  (short_events),
  .normal_events (normal_events),
  .long_events   (long_events)
);

`default_nettype wire
